@@ hw/rtl/tssl_pkg.sv @@
package tssl_pkg;

  // word and register widths
  localparam int SAMPLE_BITS = 10;
  localparam int RAW_BITS    = 10;
  localparam int OUT_BITS    = 8;
  localparam int DATA_W      = 32;

  // adjusted breakpoints carry a sign and may sit half a span outside the raw range
  localparam int BP_W = ((SAMPLE_BITS > RAW_BITS) ? SAMPLE_BITS : RAW_BITS) + 2;

  // divider: dividend is span times output step, divisor is a breakpoint distance
  localparam int DIV_N_W    = BP_W + OUT_BITS;
  localparam int DIV_D_W    = BP_W;
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEP   = (DIV_N_W + DIV_STAGES - 1) / DIV_STAGES;
  localparam int QUO_W      = DIV_STEP * DIV_STAGES;

  // select, multiply, divide stages, output register
  localparam int NSTAGE = DIV_STAGES + 3;

  // cycles after a register write until the adjusted breakpoints are current
  localparam int SETTLE_CYCLES = DIV_STAGES + 1;
  localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

  // register map
  localparam int NUM_REGS  = 7;
  localparam int PADDR_W   = $clog2(NUM_REGS * 4);
  localparam int REG_IDX_W = PADDR_W - 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RAW_LOW     = 0,
    REG_RAW_CENTRE  = 1,
    REG_RAW_HIGH    = 2,
    REG_OUT_LOW     = 3,
    REG_OUT_CENTRE  = 4,
    REG_OUT_HIGH    = 5,
    REG_ROUNDING_ON = 6
  } reg_idx_t;

  // reset values
  localparam logic [RAW_BITS-1:0]        RAW_LOW_RST    = RAW_BITS'(0);
  localparam logic [RAW_BITS-1:0]        RAW_CENTRE_RST = RAW_BITS'(511);
  localparam logic [RAW_BITS-1:0]        RAW_HIGH_RST   = RAW_BITS'(1023);
  localparam logic signed [OUT_BITS-1:0] OUT_LOW_RST    = OUT_BITS'(-127);
  localparam logic signed [OUT_BITS-1:0] OUT_CENTRE_RST = OUT_BITS'(0);
  localparam logic signed [OUT_BITS-1:0] OUT_HIGH_RST   = OUT_BITS'(127);

  typedef enum logic [1:0] {
    SEG_CLAMP_LOW  = 2'd0,
    SEG_LOWER      = 2'd1,
    SEG_UPPER      = 2'd2,
    SEG_CLAMP_HIGH = 2'd3
  } seg_t;

  // per-word side information that travels beside the divider
  typedef struct packed {
    seg_t                        seg;
    logic signed [OUT_BITS-1:0]  oa;
    logic                        neg;
  } side_t;

  // one divider stage: partial remainder, dividend bits still to shift in,
  // quotient bits so far and the divisor
  typedef struct packed {
    logic [DIV_D_W-1:0] rem;
    logic [QUO_W-1:0]   num;
    logic [QUO_W-1:0]   quo;
    logic [DIV_D_W-1:0] dvs;
  } div_st_t;

  // DIV_STEP restoring division steps, one quotient bit each
  function automatic div_st_t div_step(input div_st_t s);
    div_st_t          r;
    logic [DIV_D_W:0] trial;
    r = s;
    for (int j = 0; j < DIV_STEP; j++) begin
      trial = {r.rem, r.num[QUO_W-1]};
      r.num = {r.num[QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, r.dvs}) begin
        r.rem = DIV_D_W'(trial - {1'b0, r.dvs});
        r.quo = {r.quo[QUO_W-2:0], 1'b1};
      end else begin
        r.rem = trial[DIV_D_W-1:0];
        r.quo = {r.quo[QUO_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/tssl_sample_if.sv @@
interface tssl_sample_if;
  logic                             valid;
  logic                             ready;
  logic [tssl_pkg::SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

@@ hw/rtl/tssl_gauge_if.sv @@
interface tssl_gauge_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tssl_pkg::OUT_BITS-1:0] gauge_value;
  logic [1:0]                           segment;

  modport source (output valid, output gauge_value, output segment, input ready);
  modport sink (input valid, input gauge_value, input segment, output ready);
endinterface

@@ hw/rtl/two_segment_sensor_linearizer.sv @@
// Maps each 10-bit converter sample to a signed 8-bit gauge value over two
// linear segments with end clamps, and reports which segment was used. One
// sample is taken per clock while raw.ready is high; a result passes through
// seven register stages (select, multiply, four divider stages, output
// register), the divider working out the 20-bit quotient five bits per stage.
// The pipeline keeps taking samples while a result waits at the output, as
// long as a stage ahead is free. After reset and after every register write
// the sample channel holds ready low while the rounding-adjusted breakpoints
// are recomputed from the new calibration.
module two_segment_sensor_linearizer (
  input  logic                           clk,
  input  logic                           rst,
  tssl_sample_if.sink                    raw,
  tssl_gauge_if.source                   gauge,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tssl_pkg::PADDR_W-1:0]   paddr,
  input  logic [tssl_pkg::DATA_W-1:0]    pwdata,
  output logic [tssl_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  localparam int RB = tssl_pkg::RAW_BITS;
  localparam int OB = tssl_pkg::OUT_BITS;
  localparam int BW = tssl_pkg::BP_W;
  localparam int NS = tssl_pkg::NSTAGE;

  // magnitude of a signed raw difference
  function automatic logic [RB-1:0] raw_mag(input logic signed [RB:0] v);
    return v[RB] ? RB'(-v) : RB'(v);
  endfunction

  // magnitude of a signed output difference
  function automatic logic [OB-1:0] out_mag(input logic signed [OB:0] v);
    return v[OB] ? OB'(-v) : OB'(v);
  endfunction

  // bp less half the truncated step, no shift on zero step or rounding off
  function automatic logic signed [BW-1:0] adjusted(
    input logic [RB-1:0]              base,
    input logic                       neg,
    input logic [OB-1:0]              dmag,
    input logic [tssl_pkg::QUO_W-1:0] quo,
    input logic                       rnd
  );
    logic signed [RB:0] qs;
    logic signed [RB:0] adj;
    qs  = neg ? -$signed({1'b0, quo[RB-1:0]}) : $signed({1'b0, quo[RB-1:0]});
    if (dmag == '0 || !rnd) begin
      adj = '0;
    end else begin
      adj = qs >>> 1;
    end
    return $signed(BW'(base)) - BW'(adj);
  endfunction

  // ---------------------------------------------------------------
  // configuration registers

  logic [RB-1:0]        raw_low;
  logic [RB-1:0]        raw_centre;
  logic [RB-1:0]        raw_high;
  logic signed [OB-1:0] out_low;
  logic signed [OB-1:0] out_centre;
  logic signed [OB-1:0] out_high;
  logic                 rounding_on;
  logic                 cfg_wr;
  tssl_pkg::reg_idx_t   reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = tssl_pkg::reg_idx_t'(paddr[tssl_pkg::PADDR_W-1:2]);

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_low     <= tssl_pkg::RAW_LOW_RST;
      raw_centre  <= tssl_pkg::RAW_CENTRE_RST;
      raw_high    <= tssl_pkg::RAW_HIGH_RST;
      out_low     <= tssl_pkg::OUT_LOW_RST;
      out_centre  <= tssl_pkg::OUT_CENTRE_RST;
      out_high    <= tssl_pkg::OUT_HIGH_RST;
      rounding_on <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        tssl_pkg::REG_RAW_LOW:     raw_low     <= pwdata[RB-1:0];
        tssl_pkg::REG_RAW_CENTRE:  raw_centre  <= pwdata[RB-1:0];
        tssl_pkg::REG_RAW_HIGH:    raw_high    <= pwdata[RB-1:0];
        tssl_pkg::REG_OUT_LOW:     out_low     <= pwdata[OB-1:0];
        tssl_pkg::REG_OUT_CENTRE:  out_centre  <= pwdata[OB-1:0];
        tssl_pkg::REG_OUT_HIGH:    out_high    <= pwdata[OB-1:0];
        tssl_pkg::REG_ROUNDING_ON: rounding_on <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (reg_idx)
      tssl_pkg::REG_RAW_LOW:     prdata = tssl_pkg::DATA_W'(raw_low);
      tssl_pkg::REG_RAW_CENTRE:  prdata = tssl_pkg::DATA_W'(raw_centre);
      tssl_pkg::REG_RAW_HIGH:    prdata = tssl_pkg::DATA_W'(raw_high);
      tssl_pkg::REG_OUT_LOW:     prdata = tssl_pkg::DATA_W'(out_low);
      tssl_pkg::REG_OUT_CENTRE:  prdata = tssl_pkg::DATA_W'(out_centre);
      tssl_pkg::REG_OUT_HIGH:    prdata = tssl_pkg::DATA_W'(out_high);
      tssl_pkg::REG_ROUNDING_ON: prdata = tssl_pkg::DATA_W'(rounding_on);
      default:                   prdata = '0;
    endcase
  end

  // hold off samples until the breakpoint pipeline has caught up
  logic [tssl_pkg::SETTLE_W-1:0] settle;

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      settle <= tssl_pkg::SETTLE_W'(tssl_pkg::SETTLE_CYCLES);
    end else if (settle != '0) begin
      settle <= settle - 1'b1;
    end
  end

  // ---------------------------------------------------------------
  // breakpoint adjustment, free running from the registers

  logic signed [RB:0]        num_lo, num_mid, num_hi;
  logic signed [OB:0]        dif_lo, dif_mid, dif_hi;
  logic [OB-1:0]             dmag_lo, dmag_mid, dmag_hi;
  logic [tssl_pkg::QUO_W-1:0] quo_lo, quo_mid, quo_hi;
  logic signed [BW-1:0]      bp_lo, bp_mid, bp_hi;

  assign num_lo  = $signed({1'b0, raw_centre}) - $signed({1'b0, raw_low});
  assign num_mid = $signed({1'b0, raw_high}) - $signed({1'b0, raw_low});
  assign num_hi  = $signed({1'b0, raw_high}) - $signed({1'b0, raw_centre});
  assign dif_lo  = (OB+1)'(out_centre) - (OB+1)'(out_low);
  assign dif_mid = (OB+1)'(out_high) - (OB+1)'(out_low);
  assign dif_hi  = (OB+1)'(out_high) - (OB+1)'(out_centre);
  assign dmag_lo  = out_mag(dif_lo);
  assign dmag_mid = out_mag(dif_mid);
  assign dmag_hi  = out_mag(dif_hi);

  tssl_div u_div_lo (
    .clk      (clk),
    .en       ('1),
    .dividend (tssl_pkg::QUO_W'(raw_mag(num_lo))),
    .divisor  (tssl_pkg::DIV_D_W'(dmag_lo)),
    .quotient (quo_lo)
  );

  tssl_div u_div_mid (
    .clk      (clk),
    .en       ('1),
    .dividend (tssl_pkg::QUO_W'(raw_mag(num_mid))),
    .divisor  (tssl_pkg::DIV_D_W'(dmag_mid)),
    .quotient (quo_mid)
  );

  tssl_div u_div_hi (
    .clk      (clk),
    .en       ('1),
    .dividend (tssl_pkg::QUO_W'(raw_mag(num_hi))),
    .divisor  (tssl_pkg::DIV_D_W'(dmag_hi)),
    .quotient (quo_hi)
  );

  always_ff @(posedge clk) begin
    bp_lo  <= adjusted(raw_low, num_lo[RB], dmag_lo, quo_lo, rounding_on);
    bp_mid <= adjusted(raw_centre, num_mid[RB], dmag_mid, quo_mid, rounding_on);
    bp_hi  <= adjusted(raw_high, num_hi[RB], dmag_hi, quo_hi, rounding_on);
  end

  // ---------------------------------------------------------------
  // sample pipeline handshake

  logic [NS:1] vld;
  logic [NS:1] rdy;

  always_comb begin
    rdy[NS] = !vld[NS] || gauge.ready;
    for (int k = NS - 1; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign raw.ready = rdy[1] && (settle == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= raw.valid && (settle == '0);
      end
      for (int k = 2; k <= NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // stage 1: segment select and segment distances

  logic signed [BW-1:0] x_s, a_s, b_s;
  logic signed [OB-1:0] oa_s, ob_s;
  logic signed [OB:0]   d_s;
  tssl_pkg::seg_t       seg_s;

  always_comb begin
    x_s   = $signed(BW'(raw.sample));
    a_s   = bp_lo;
    b_s   = bp_mid;
    oa_s  = out_low;
    ob_s  = out_centre;
    seg_s = tssl_pkg::SEG_CLAMP_LOW;
    if (x_s <= bp_lo) begin
      seg_s = tssl_pkg::SEG_CLAMP_LOW;
    end else if (x_s >= bp_hi) begin
      seg_s = tssl_pkg::SEG_CLAMP_HIGH;
      oa_s  = out_high;
    end else if (x_s <= bp_mid) begin
      seg_s = tssl_pkg::SEG_LOWER;
    end else begin
      seg_s = tssl_pkg::SEG_UPPER;
      a_s   = bp_mid;
      b_s   = bp_hi;
      oa_s  = out_centre;
      ob_s  = out_high;
    end
    d_s = (OB+1)'(ob_s) - (OB+1)'(oa_s);
  end

  tssl_pkg::side_t side [1:NS-1];
  logic [BW-1:0]   span1;
  logic [BW-1:0]   den1;
  logic [OB-1:0]   mag1;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      span1   <= BW'(x_s - a_s);
      den1    <= BW'(b_s - a_s);
      mag1    <= out_mag(d_s);
    end
  end

  // stage 2: span times output step

  logic [tssl_pkg::QUO_W-1:0]   prod2;
  logic [tssl_pkg::DIV_D_W-1:0] den2;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      prod2 <= tssl_pkg::QUO_W'({{OB{1'b0}}, span1} * {{BW{1'b0}}, mag1});
      den2  <= tssl_pkg::DIV_D_W'(den1);
    end
  end

  // side information follows the word down the pipeline
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      side[1] <= '{seg: seg_s, oa: oa_s, neg: d_s[OB]};
    end
    for (int k = 2; k <= NS - 1; k++) begin
      if (rdy[k]) begin
        side[k] <= side[k-1];
      end
    end
  end

  // stages 3 to 6: interpolation divide
  logic [tssl_pkg::QUO_W-1:0] item_quo;

  tssl_div u_div_item (
    .clk      (clk),
    .en       (rdy[NS-1:3]),
    .dividend (prod2),
    .divisor  (den2),
    .quotient (item_quo)
  );

  // ---------------------------------------------------------------
  // output stage: sign, offset and clamp, wrapped to 8 bits

  logic [OB-1:0]  q_val;
  logic [OB-1:0]  gv_next;
  logic [OB-1:0]  gv;
  tssl_pkg::seg_t seg_out;

  always_comb begin
    q_val = side[NS-1].neg ? OB'(-item_quo[OB-1:0]) : item_quo[OB-1:0];
    if (side[NS-1].seg == tssl_pkg::SEG_CLAMP_LOW ||
        side[NS-1].seg == tssl_pkg::SEG_CLAMP_HIGH) begin
      gv_next = side[NS-1].oa;
    end else begin
      gv_next = OB'(q_val + side[NS-1].oa);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NS]) begin
      gv      <= gv_next;
      seg_out <= side[NS-1].seg;
    end
  end

  assign gauge.valid       = vld[NS];
  assign gauge.gauge_value = gv;
  assign gauge.segment     = seg_out;

`ifndef SYNTHESIS
  // no sample enters while the breakpoints are stale
  a_settle_blocks: assert property (@(posedge clk) disable iff (rst)
    (settle != '0) |-> !raw.ready)
    else $error("sample taken while breakpoints settle");

  // every register write restarts the settle count
  a_write_restarts: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> (settle == tssl_pkg::SETTLE_W'(tssl_pkg::SETTLE_CYCLES)))
    else $error("register write did not restart settle count");

  // a blocked word in the last divider stage stays put
  a_div_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (vld[NS-1] && !rdy[NS-1]) |=> (vld[NS-1] && $stable(side[NS-1])))
    else $error("stalled word lost in divider stage");
`endif

endmodule

@@ hw/rtl/tssl_div.sv @@
module tssl_div (
  input  logic                          clk,
  input  logic [tssl_pkg::DIV_STAGES-1:0] en,
  input  logic [tssl_pkg::QUO_W-1:0]    dividend,
  input  logic [tssl_pkg::DIV_D_W-1:0]  divisor,
  output logic [tssl_pkg::QUO_W-1:0]    quotient
);

  tssl_pkg::div_st_t st_in [tssl_pkg::DIV_STAGES];
  tssl_pkg::div_st_t st_nx [tssl_pkg::DIV_STAGES];
  tssl_pkg::div_st_t st    [tssl_pkg::DIV_STAGES];

  // stage inputs: first stage from the ports, the rest from the stage before
  always_comb begin
    st_in[0] = '{rem: '0, num: dividend, quo: '0, dvs: divisor};
    for (int s = 1; s < tssl_pkg::DIV_STAGES; s++) begin
      st_in[s] = st[s-1];
    end
    for (int s = 0; s < tssl_pkg::DIV_STAGES; s++) begin
      st_nx[s] = tssl_pkg::div_step(st_in[s]);
    end
  end

  // each stage holds while its enable is low
  always_ff @(posedge clk) begin
    for (int s = 0; s < tssl_pkg::DIV_STAGES; s++) begin
      if (en[s]) begin
        st[s] <= st_nx[s];
      end
    end
  end

  assign quotient = st[tssl_pkg::DIV_STAGES-1].quo;

endmodule

@@ tb/sv/two_segment_sensor_linearizer_tb.sv @@
module two_segment_sensor_linearizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tssl_pkg::*;

  localparam int CLK_PERIOD    = 4;
  localparam int RESET_CYCLES  = 6;
  localparam int HOLD_CYCLES   = 60;
  localparam int QUIET_LIMIT   = 5000;
  localparam int PHASES        = 12;
  localparam int PHASE_SAMPLES = 79;
  localparam int MAX_REPORTS   = 100;
  localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;

  // index just past the register map, writes there must change nothing
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = REG_IDX_W'(NUM_REGS);

  // sender idle and receiver stall percentages per idling phase
  localparam int SENDER_IDLE[4]    = '{0, 70, 0, 17};
  localparam int RECEIVER_STALL[4] = '{0, 0, 70, 17};

  localparam logic [SAMPLE_BITS-1:0] DIRECTED[12] = '{
    0, 1, 2, 255, 510, 511, 512, 513, 767, 1022, 1023, 10'h2AA
  };
  localparam logic [RAW_BITS-1:0] RAW_CORNERS[5] = '{0, 1, 511, 1022, 1023};
  localparam logic [OUT_BITS-1:0] OUT_CORNERS[5] = '{8'h80, 8'h81, 8'hFF, 8'h00, 8'h7F};

  typedef enum int {
    CAL_ANY,
    CAL_ORDERED,
    CAL_CORNER,
    CAL_FLAT
  } cal_kind_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] gauge;
    seg_t                       seg;
  } gauge_word_t;

  // calibration copy, gauge prediction and the queue of gauge words still due
  class gauge_checker;
    logic [RAW_BITS-1:0]        raw_low, raw_centre, raw_high;
    logic signed [OUT_BITS-1:0] out_low, out_centre, out_high;
    logic                       rounding_on;
    gauge_word_t                expected_gauges[$];
    int unsigned                n_errors;

    function new();
      raw_low     = RAW_LOW_RST;
      raw_centre  = RAW_CENTRE_RST;
      raw_high    = RAW_HIGH_RST;
      out_low     = OUT_LOW_RST;
      out_centre  = OUT_CENTRE_RST;
      out_high    = OUT_HIGH_RST;
      rounding_on = 1'b0;
      n_errors    = 0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_RAW_LOW:     raw_low     = value[RAW_BITS-1:0];
        REG_RAW_CENTRE:  raw_centre  = value[RAW_BITS-1:0];
        REG_RAW_HIGH:    raw_high    = value[RAW_BITS-1:0];
        REG_OUT_LOW:     out_low     = value[OUT_BITS-1:0];
        REG_OUT_CENTRE:  out_centre  = value[OUT_BITS-1:0];
        REG_OUT_HIGH:    out_high    = value[OUT_BITS-1:0];
        REG_ROUNDING_ON: rounding_on = value[0];
        default: ;
      endcase
    endfunction

    // half a step, floored; a flat step shifts nothing
    function int half_step(int span, int oa, int ob);
      int d;
      d = (ob > oa) ? ob - oa : oa - ob;
      if (d == 0) return 0;
      return (span / d) >>> 1;
    endfunction

    // truncating interpolation, wrapped to the gauge width
    function logic [OUT_BITS-1:0] lerp(int x, int a, int b, int oa, int ob);
      int den;
      int q;
      den = b - a;
      q   = (den == 0) ? 0 : ((x - a) * (ob - oa)) / den;
      return OUT_BITS'(q + oa);
    endfunction

    function gauge_word_t predict_gauge(logic [SAMPLE_BITS-1:0] s);
      int          x, lo, mid, hi, ol, oc, oh;
      gauge_word_t w;
      x   = int'(s);
      lo  = int'(raw_low);
      mid = int'(raw_centre);
      hi  = int'(raw_high);
      ol  = int'(out_low);
      oc  = int'(out_centre);
      oh  = int'(out_high);
      // breakpoints lowered from the raw calibration, not from each other
      if (rounding_on) begin
        lo  = int'(raw_low) - half_step(int'(raw_centre) - int'(raw_low), ol, oc);
        mid = int'(raw_centre) - half_step(int'(raw_high) - int'(raw_low), ol, oh);
        hi  = int'(raw_high) - half_step(int'(raw_high) - int'(raw_centre), oc, oh);
      end
      if (x <= lo) begin
        w.gauge = out_low;
        w.seg   = SEG_CLAMP_LOW;
      end else if (x >= hi) begin
        w.gauge = out_high;
        w.seg   = SEG_CLAMP_HIGH;
      end else if (x <= mid) begin
        w.gauge = lerp(x, lo, mid, ol, oc);
        w.seg   = SEG_LOWER;
      end else begin
        w.gauge = lerp(x, mid, hi, oc, oh);
        w.seg   = SEG_UPPER;
      end
      return w;
    endfunction

    function void note_sample(logic [SAMPLE_BITS-1:0] s);
      expected_gauges.push_back(predict_gauge(s));
    endfunction

    function void check_result(logic [OUT_BITS-1:0] gauge, logic [1:0] seg);
      gauge_word_t w;
      if (expected_gauges.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $error("unexpected gauge word: gauge_value %0d, segment %0d", $signed(gauge), seg);
        return;
      end
      w = expected_gauges.pop_front();
      if (gauge !== w.gauge) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $error("gauge_value: expected %0d, actual %0d", $signed(w.gauge), $signed(gauge));
      end
      if (seg !== w.seg) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $error("segment: expected %0d, actual %0d", w.seg, seg);
      end
    endfunction
  endclass

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0]  pwdata  = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int idle_pct     = 0;
  int stall_pct    = 0;
  bit hold_pending = 1'b0;
  int quiet_cycles = 0;

  gauge_checker gauges = new();

  tssl_sample_if raw_if ();
  tssl_gauge_if  gauge_if ();

  two_segment_sensor_linearizer i_dut (
    .clk     (clk),
    .rst     (rst),
    .raw     (raw_if),
    .gauge   (gauge_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic bit chance(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // field in the low bits, random junk above it
  function automatic logic [DATA_W-1:0] pad_word(logic [DATA_W-1:0] field, int width);
    logic [DATA_W-1:0] mask;
    mask = (DATA_W'(1) << width) - 1;
    return (DATA_W'($urandom) & ~mask) | (field & mask);
  endfunction

  // uniform, near a breakpoint, or at the ends of the range
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int                  v;
    int                  off;
    logic [RAW_BITS-1:0] bp;
    case ($urandom_range(3, 0))
      0: begin
        case ($urandom_range(2, 0))
          0:       bp = gauges.raw_low;
          1:       bp = gauges.raw_centre;
          default: bp = gauges.raw_high;
        endcase
        off = $urandom_range(6, 0);
        v   = int'(bp) + off - 3;
        if (v < 0) v = 0;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      end
      1: begin
        case ($urandom_range(3, 0))
          0:       v = 0;
          1:       v = 1;
          2:       v = SAMPLE_MAX - 1;
          default: v = SAMPLE_MAX;
        endcase
      end
      default: v = $urandom_range(SAMPLE_MAX, 0);
    endcase
    return SAMPLE_BITS'(v);
  endfunction

  // setup cycle, then access cycle; register taken when pready is seen
  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    gauges.set_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_calibration(input logic [RAW_BITS-1:0] rl, rc, rh,
                                   input logic [OUT_BITS-1:0] ol, oc, oh,
                                   input logic rnd);
    apb_write(REG_RAW_LOW, pad_word(DATA_W'(rl), RAW_BITS));
    apb_write(REG_RAW_CENTRE, pad_word(DATA_W'(rc), RAW_BITS));
    apb_write(REG_RAW_HIGH, pad_word(DATA_W'(rh), RAW_BITS));
    apb_write(REG_OUT_LOW, pad_word(DATA_W'(ol), OUT_BITS));
    apb_write(REG_OUT_CENTRE, pad_word(DATA_W'(oc), OUT_BITS));
    apb_write(REG_OUT_HIGH, pad_word(DATA_W'(oh), OUT_BITS));
    apb_write(REG_ROUNDING_ON, pad_word(DATA_W'(rnd), 1));
  endtask

  task automatic choose_calibration(input cal_kind_t kind);
    logic [RAW_BITS-1:0] r0, r1, r2, t;
    logic [OUT_BITS-1:0] o0, o1, o2;
    logic                rnd;
    r0  = RAW_BITS'($urandom);
    r1  = RAW_BITS'($urandom);
    r2  = RAW_BITS'($urandom);
    o0  = OUT_BITS'($urandom);
    o1  = OUT_BITS'($urandom);
    o2  = OUT_BITS'($urandom);
    rnd = 1'($urandom);
    if (kind == CAL_CORNER) begin
      r0 = RAW_CORNERS[$urandom_range(4, 0)];
      r1 = RAW_CORNERS[$urandom_range(4, 0)];
      r2 = RAW_CORNERS[$urandom_range(4, 0)];
      o0 = OUT_CORNERS[$urandom_range(4, 0)];
      o1 = OUT_CORNERS[$urandom_range(4, 0)];
      o2 = OUT_CORNERS[$urandom_range(4, 0)];
    end
    // ascending breakpoints
    if (kind == CAL_ORDERED || kind == CAL_FLAT) begin
      if (r0 > r1) begin t = r0; r0 = r1; r1 = t; end
      if (r1 > r2) begin t = r1; r1 = r2; r2 = t; end
      if (r0 > r1) begin t = r0; r0 = r1; r1 = t; end
    end
    // zero step width on one or both segments
    if (kind == CAL_FLAT) begin
      case ($urandom_range(2, 0))
        0:       o1 = o0;
        1:       o2 = o1;
        default: begin
          o1 = o0;
          o2 = o0;
        end
      endcase
      rnd = 1'b1;
    end
    apply_calibration(r0, r1, r2, o0, o1, o2, rnd);
  endtask

  // offer one word, idling first as the phase asks
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
    @(negedge clk);
    while (chance(idle_pct)) begin
      raw_if.valid <= 1'b0;
      @(negedge clk);
    end
    raw_if.valid  <= 1'b1;
    raw_if.sample <= s;
    do @(posedge clk); while (!raw_if.ready);
    gauges.note_sample(s);
  endtask

  // stop offering and wait for every gauge word still due
  task automatic settle();
    @(negedge clk);
    raw_if.valid <= 1'b0;
    while (gauges.expected_gauges.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, with a long hold-off on request
  initial begin : gauge_sink
    gauge_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        gauge_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gauge_if.ready <= !chance(stall_pct);
    end
  end

  // result check on every accepted gauge word
  always @(posedge clk) begin
    if (!rst && gauge_if.valid === 1'b1 && gauge_if.ready === 1'b1)
      gauges.check_result(gauge_if.gauge_value, gauge_if.segment);
  end

  // watchdog on cycles with no word moving anywhere
  always @(posedge clk) begin
    if (rst || (raw_if.valid && raw_if.ready) || (gauge_if.valid && gauge_if.ready) ||
        (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    cal_kind_t kind;
    raw_if.valid  = 1'b0;
    raw_if.sample = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset calibration, plain then with rounding; unused index changes nothing
    foreach (DIRECTED[i]) send_sample(DIRECTED[i]);
    settle();
    apb_write(REG_UNUSED, '1);
    apb_write(REG_ROUNDING_ON, pad_word(DATA_W'(1), 1));
    foreach (DIRECTED[i]) send_sample(DIRECTED[i]);

    // random phases, each with its own calibration; idling changes every third phase
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      idle_pct  = SENDER_IDLE[(ph / 3) % 4];
      stall_pct = RECEIVER_STALL[(ph / 3) % 4];
      kind      = cal_kind_t'(ph % 4);
      if (ph == 2)
        apply_calibration(0, 511, 1023, OUT_BITS'(-128), OUT_BITS'(127), OUT_BITS'(-128), 1'b1);
      else if (ph == 6)
        apply_calibration(1023, 1023, 1023, OUT_BITS'(127), OUT_BITS'(-128), OUT_BITS'(127),
                          1'b0);
      else
        choose_calibration(kind);
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        // long receiver hold-off while words keep coming, to fill the pipeline
        if (ph == 1 && n == 20) hold_pending = 1'b1;
        send_sample(pick_sample());
      end
    end

    settle();
    repeat (NSTAGE + 4) @(posedge clk);
    if (gauges.n_errors == 0 && gauges.expected_gauges.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
